/* rtl/rwv_pkg.sv */
// ----------------------------------------------------------------------------
// rwv_pkg
// Shared constants, register map and controller states for the ring window
// variance block.
// ----------------------------------------------------------------------------
package rwv_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 32;
  localparam int unsigned WINDOW_DEF      = 16;
  localparam int unsigned SAMPLE_BITS_DEF = 10;

  localparam int unsigned VAR_W   = 7;
  localparam int unsigned VAR_MAX = 127;
  localparam int unsigned OUT_W   = 8;

  localparam int unsigned RING_LEN_W = 6;
  localparam logic [RING_LEN_W-1:0] RING_LEN_RST = 6'd32;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Register index, taken from the word address.
  localparam logic REG_RING_LENGTH = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SQUARE,
    S_DIV1,
    S_WAIT1,
    S_SUB,
    S_CHECK,
    S_DIV2,
    S_WAIT2,
    S_LOAD
  } rwv_state_e;

endpackage

/* rtl/rwv_store.sv */
// ----------------------------------------------------------------------------
// rwv_store
// Sample ring memory with one write port and one registered read port.
// Entries that were never written since reset read as zero.
// ----------------------------------------------------------------------------
module rwv_store #(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned DATA_W = 10,
  parameter int unsigned ADDR_W = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  logic [DATA_W-1:0] rd_data_q;
  logic              rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

/* rtl/rwv_div.sv */
// ----------------------------------------------------------------------------
// rwv_div
// Division by a constant through a multiplication with its reciprocal.
// The quotient is registered in the cycle after start and flagged by done.
// ----------------------------------------------------------------------------
module rwv_div #(
  parameter int unsigned XW      = 28,
  parameter int unsigned DIVISOR = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [XW-1:0] dividend_i,
  output logic          done_o,
  output logic [XW-1:0] quot_o
);

  // The reciprocal is rounded up and carries XW plus clog2(DIVISOR) fraction
  // bits, which keeps the quotient exact for every XW-bit dividend.
  localparam int unsigned Shift  = XW + $clog2(DIVISOR);
  localparam int unsigned RecipW = Shift + 1;
  localparam int unsigned ProdW  = XW + RecipW;
  localparam logic [RecipW-1:0] Recip =
    ((RecipW'(1) << Shift) + RecipW'(DIVISOR - 1)) / RecipW'(DIVISOR);

  logic [ProdW-1:0] prod;
  logic [XW-1:0]    quot_q;
  logic             done_q;

  assign prod = ProdW'(dividend_i) * ProdW'(Recip);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= prod[Shift +: XW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* rtl/ring_window_variance.sv */
// ----------------------------------------------------------------------------
// ring_window_variance
// Windowed sample variance over a ring store of sensor samples.
//
// Each transaction on the s_axis channel carries one sample. The sample is
// written into the ring memory at the write pointer, which then advances and
// wraps at the ring_length register or at the memory depth. The block then
// reads the first WINDOW entries one per cycle, accumulates the sum and the
// sum of squares, and runs up to two divisions by constants, each a
// registered multiplication by a reciprocal. One result transaction leaves
// on m_axis for every input transaction. A window with a zero entry, or a
// window larger than the store, skips both divisions and yields zero; a
// saturated result skips the second division. The block takes the next
// sample as soon as the result sits in the output register, even while the
// receiver still stalls it. The APB port writes and reads ring_length at
// address 0; write it only while the block is idle. Reset makes the memory
// read as zero, sets the write pointer to one and ring_length to 32.
// ----------------------------------------------------------------------------
module ring_window_variance #(
  parameter int unsigned STORE_DEPTH = rwv_pkg::STORE_DEPTH_DEF,
  parameter int unsigned WINDOW      = rwv_pkg::WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = rwv_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned InW        = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [InW-1:0]                  s_axis_tdata,  // [SAMPLE_BITS-1:0] sample
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [rwv_pkg::OUT_W-1:0]       m_axis_tdata,  // [6:0] variance
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rwv_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rwv_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rwv_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  import rwv_pkg::*;

  localparam int unsigned PW       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned LW       = $clog2(WINDOW);
  localparam int unsigned SumW     = SAMPLE_BITS + LW;
  localparam int unsigned SqW      = 2 * SAMPLE_BITS + LW;
  localparam int unsigned SampSqW  = 2 * SAMPLE_BITS;
  localparam int unsigned DW       = 2 * SumW;
  localparam int unsigned KW       = $clog2(WINDOW + 1);
  localparam int unsigned CW       = (PW + 1 > RING_LEN_W) ? PW + 1 : RING_LEN_W;
  localparam int unsigned SatLimit = (VAR_MAX + 1) * (WINDOW - 1);
  localparam int unsigned QW       = $clog2(SatLimit);
  localparam bit          WinFits  = (WINDOW <= STORE_DEPTH);

  rwv_state_e state_q, state_d;

  logic [RING_LEN_W-1:0]  ring_len_q;
  logic [PW-1:0]          wp_q;
  logic [CW-1:0]          wp_next;
  logic [KW-1:0]          cnt_q;
  logic                   rd_pend_q;
  logic                   sq_pend_q;
  logic                   zero_q;
  logic [SAMPLE_BITS-1:0] rd_value;
  logic [SampSqW-1:0]     sq_q;
  logic [SumW-1:0]        sum_q;
  logic [SqW-1:0]         sumsq_q;
  logic [DW-1:0]          ssq_q;
  logic [SqW-1:0]         diff_q;
  logic [VAR_W-1:0]       res_q;
  logic                   out_valid_q;
  logic [VAR_W-1:0]       out_data_q;

  logic                   in_fire;
  logic                   issue;
  logic                   load;
  logic                   div1_start;
  logic                   div1_done;
  logic [DW-1:0]          div1_quot;
  logic                   div2_start;
  logic                   div2_done;
  logic [QW-1:0]          div2_quot;
  logic                   cfg_wr;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_RING_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_len_q <= RING_LEN_RST;
    end else if (cfg_wr) begin
      ring_len_q <= pwdata[RING_LEN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_RING_LENGTH) ? APB_DATA_W'(ring_len_q) : '0;

  // Write pointer.
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign wp_next = CW'(wp_q) + CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= PW'(1);
    end else if (in_fire) begin
      if (wp_next >= CW'(ring_len_q) || wp_next >= CW'(STORE_DEPTH)) begin
        wp_q <= '0;
      end else begin
        wp_q <= wp_next[PW-1:0];
      end
    end
  end

  rwv_store #(
    .DEPTH  (STORE_DEPTH),
    .DATA_W (SAMPLE_BITS),
    .ADDR_W (PW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_fire),
    .wr_addr_i (wp_q),
    .wr_data_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .rd_en_i   (issue && WinFits),
    .rd_addr_i (PW'(cnt_q)),
    .rd_data_o (rd_value)
  );

  rwv_div #(
    .XW      (DW),
    .DIVISOR (WINDOW)
  ) u_div_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div1_start),
    .dividend_i (ssq_q),
    .done_o     (div1_done),
    .quot_o     (div1_quot)
  );

  rwv_div #(
    .XW      (QW),
    .DIVISOR (WINDOW - 1)
  ) u_div_dof (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div2_start),
    .dividend_i (diff_q[QW-1:0]),
    .done_o     (div2_done),
    .quot_o     (div2_quot)
  );

  // Controller.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    div1_start    = 1'b0;
    div2_start    = 1'b0;
    load          = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        issue = (cnt_q < KW'(WINDOW));
        if (!issue && !rd_pend_q && !sq_pend_q) begin
          state_d = S_SQUARE;
        end
      end
      S_SQUARE: begin
        state_d = (zero_q || !WinFits) ? S_LOAD : S_DIV1;
      end
      S_DIV1: begin
        div1_start = 1'b1;
        state_d    = S_WAIT1;
      end
      S_WAIT1: begin
        if (div1_done) begin
          state_d = S_SUB;
        end
      end
      S_SUB: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d = (diff_q >= SqW'(SatLimit)) ? S_LOAD : S_DIV2;
      end
      S_DIV2: begin
        div2_start = 1'b1;
        state_d    = S_WAIT2;
      end
      S_WAIT2: begin
        if (div2_done) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Scan pipeline: read, then square, then accumulate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
      sq_pend_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      rd_pend_q <= issue;
      sq_pend_q <= rd_pend_q;
      if (in_fire) begin
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sum_q   <= '0;
      sumsq_q <= '0;
      zero_q  <= 1'b0;
    end else begin
      if (rd_pend_q) begin
        sq_q  <= SampSqW'(rd_value) * SampSqW'(rd_value);
        sum_q <= sum_q + SumW'(rd_value);
        if (rd_value == '0) begin
          zero_q <= 1'b1;
        end
      end
      if (sq_pend_q) begin
        sumsq_q <= sumsq_q + SqW'(sq_q);
      end
    end
    if (state_q == S_SQUARE) begin
      ssq_q <= DW'(sum_q) * DW'(sum_q);
      res_q <= '0;
    end
    if (state_q == S_SUB) begin
      diff_q <= sumsq_q - div1_quot[SqW-1:0];
    end
    if (state_q == S_CHECK) begin
      res_q <= VAR_W'(VAR_MAX);
    end
    if (state_q == S_WAIT2 && div2_done) begin
      res_q <= div2_quot[VAR_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= res_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(out_data_q);

  // Assertions.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("block accepted a sample while busy");

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(wp_q) < CW'(STORE_DEPTH))
    else $error("write pointer left the store");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div1_done || div2_done) |-> (state_q == S_WAIT1 || state_q == S_WAIT2))
    else $error("divider finished outside a wait state");

  a_zero_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD && res_q != '0) |-> (!zero_q && WinFits))
    else $error("nonzero result for a window holding a zero entry");

endmodule
